FILE: rtl/lsd_pkg.sv
// Shared types and constants for the byte radix sort unit.
`timescale 1ns / 1ps

package lsd_pkg;

    localparam int KEY_W   = 32;
    localparam int DIGIT_W = 8;
    localparam int RADIX   = 256;

    // Item kind carried in tuser on the slave side.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result status carried in tuser on the master side.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_LH_RD,
        ST_LH_WR,
        ST_PF_RD,
        ST_PF_WR,
        ST_SC_KEY,
        ST_SC_HIST,
        ST_SC_WR,
        ST_READ,
        ST_RDATA
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic capture;     // latch a load transfer, open a new set if sorted
        logic store_key;   // write key into store A, bump key count
        logic lh_rd;       // histogram read for the load key
        logic lh_wr;       // histogram increment for the load key
        logic pf_rd;       // prefix scan read
        logic pf_wr;       // prefix scan write
        logic sc_hist_rd;  // scatter: read bucket position
        logic sc_wr;       // scatter: write key, bump bucket
        logic pass_next;   // advance to next byte pass
        logic finish;      // mark set as sorted
        logic clr_wr;      // clear one histogram entry
        logic rd_issue;    // read result store at read position
        logic out_load;    // load sorted key into output register
        logic out_err;     // load empty status into output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic full;
        logic last;
        logic byte_end;
        logic dig_end;
        logic idx_end;
        logic clr_end;
        logic rd_ok;
    } t_sts;

endpackage

FILE: rtl/lsd_byte_radix_sort_unit.sv
// Top level of the LSD byte radix sort unit.
//
// Channel  Dir  Transfer when             Payload
// s        in   i_s_tvalid & o_s_tready   tdata key_in, tuser operation, tlast load_last
// m        out  o_m_tvalid & i_m_tready   tdata key_out, tuser status, tlast final_key
//
// A load does one histogram read and write per key byte on the histogram RAM; a read
// waits until the output register is free, then loads the result into it.
// The sort after the marked load runs KEY_BYTES passes, each a prefix scan over the
// 256 buckets and a scatter of every key, then clears all KEY_BYTES*256 histogram
// entries; reset starts with that same clearing pass. No transfer is taken meanwhile.
// A stalled result stays in the output register; loads are still taken behind it.
`timescale 1ns / 1ps

module lsd_byte_radix_sort_unit #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_BYTES = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [lsd_pkg::KEY_W-1:0] i_s_tdata,  // [31:0] key_in
    input  logic [0:0]                i_s_tuser,  // [0] operation
    input  logic                      i_s_tlast,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [lsd_pkg::KEY_W-1:0] o_m_tdata,  // [31:0] key_out
    output logic [0:0]                o_m_tuser,  // [0] status
    output logic                      o_m_tlast
);

    lsd_pkg::t_cmd cmd;
    lsd_pkg::t_sts sts;
    logic          status;

    lsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_op     (i_s_tuser[0]),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    lsd_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_key    (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_key    (o_m_tdata),
        .o_final  (o_m_tlast),
        .o_status (status)
    );

    assign o_m_tuser[0] = status;

endmodule

FILE: rtl/lsd_ram.sv
// Simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module lsd_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lsd_dp.sv
// Datapath: key stores, histograms, counters and output register.
`timescale 1ns / 1ps

module lsd_dp #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_BYTES = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lsd_pkg::t_cmd            i_cmd,
    output lsd_pkg::t_sts            o_sts,
    input  logic [lsd_pkg::KEY_W-1:0] i_key,
    input  logic                     i_last,
    output logic [lsd_pkg::KEY_W-1:0] o_key,
    output logic                     o_final,
    output logic                     o_status
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int HD    = KEY_BYTES * lsd_pkg::RADIX;
    localparam int HAW   = $clog2(HD);
    localparam int BW    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam bit RES_B = (KEY_BYTES % 2) == 1;

    logic [lsd_pkg::KEY_W-1:0]   r_key;
    logic                        r_last;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_rdpos;
    logic                        r_sorted;
    logic [BW-1:0]               r_byte;
    logic [lsd_pkg::DIGIT_W-1:0] r_dig;
    logic [CW-1:0]               r_idx;
    logic [CW-1:0]               r_sum;
    logic [HAW-1:0]              r_clr;
    logic [HAW-1:0]              r_haddr;
    logic [lsd_pkg::KEY_W-1:0]   r_key_out;
    logic                        r_final;
    logic                        r_status;

    logic [lsd_pkg::KEY_W-1:0]   a_rdata;
    logic [lsd_pkg::KEY_W-1:0]   b_rdata;
    logic [lsd_pkg::KEY_W-1:0]   src_rdata;
    logic [lsd_pkg::KEY_W-1:0]   res_rdata;
    logic [CW-1:0]               h_rdata;
    logic                        src_b;
    logic                        byte_end;
    logic [AW-1:0]               k_raddr;
    logic                        a_we;
    logic [AW-1:0]               a_waddr;
    logic                        b_we;
    logic [lsd_pkg::DIGIT_W-1:0] h_dig;
    logic [HAW-1:0]              h_raddr;
    logic                        h_we;
    logic [HAW-1:0]              h_waddr;
    logic [CW-1:0]               h_wdata;

    // Byte idx of a key; bytes above the key width read as zero.
    function automatic logic [lsd_pkg::DIGIT_W-1:0] f_digit(
        input logic [lsd_pkg::KEY_W-1:0] key,
        input logic [2:0]                idx
    );
        logic [2*lsd_pkg::KEY_W-1:0] wide;
        wide = {{lsd_pkg::KEY_W{1'b0}}, key} >> {idx, 3'b000};
        return wide[lsd_pkg::DIGIT_W-1:0];
    endfunction

    assign src_b     = r_byte[0];
    assign src_rdata = src_b ? b_rdata : a_rdata;
    assign res_rdata = RES_B ? b_rdata : a_rdata;
    assign byte_end  = (r_byte == BW'(KEY_BYTES - 1));

    assign k_raddr = i_cmd.rd_issue ? r_rdpos[AW-1:0] : r_idx[AW-1:0];
    assign a_we    = i_cmd.store_key | (i_cmd.sc_wr & src_b);
    assign a_waddr = i_cmd.store_key ? r_count[AW-1:0] : h_rdata[AW-1:0];
    assign b_we    = i_cmd.sc_wr & ~src_b;

    always_comb begin
        if (i_cmd.lh_rd) begin
            h_dig = f_digit(r_key, 3'(r_byte));
        end else if (i_cmd.sc_hist_rd) begin
            h_dig = f_digit(src_rdata, 3'(r_byte));
        end else begin
            h_dig = r_dig;
        end
        h_raddr = HAW'({r_byte, h_dig});
    end

    assign h_we    = i_cmd.lh_wr | i_cmd.pf_wr | i_cmd.sc_wr | i_cmd.clr_wr;
    assign h_waddr = i_cmd.clr_wr ? r_clr : r_haddr;

    always_comb begin
        if (i_cmd.clr_wr) begin
            h_wdata = '0;
        end else if (i_cmd.pf_wr) begin
            h_wdata = r_sum;
        end else begin
            h_wdata = h_rdata + CW'(1);
        end
    end

    lsd_ram #(.W(lsd_pkg::KEY_W), .D(CAPACITY)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (r_key),
        .i_raddr (k_raddr),
        .o_rdata (a_rdata)
    );

    lsd_ram #(.W(lsd_pkg::KEY_W), .D(CAPACITY)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (h_rdata[AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (k_raddr),
        .o_rdata (b_rdata)
    );

    lsd_ram #(.W(CW), .D(HD)) u_hist (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rdpos  <= '0;
            r_sorted <= 1'b0;
            r_byte   <= '0;
            r_dig    <= '0;
            r_idx    <= '0;
            r_sum    <= '0;
            r_clr    <= '0;
        end else begin
            if (i_cmd.capture && r_sorted) begin
                r_count  <= '0;
                r_rdpos  <= '0;
                r_sorted <= 1'b0;
            end
            if (i_cmd.store_key) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.lh_wr || i_cmd.pass_next) begin
                r_byte <= byte_end ? '0 : r_byte + BW'(1);
            end
            if (i_cmd.pass_next) begin
                r_idx <= '0;
            end
            if (i_cmd.pf_wr) begin
                r_dig <= r_dig + lsd_pkg::DIGIT_W'(1);
                // restart the running sum once the last bucket is written
                r_sum <= (r_dig == '1) ? '0 : r_sum + h_rdata;
            end
            if (i_cmd.sc_wr) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.finish) begin
                r_sorted <= 1'b1;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= (r_clr == HAW'(HD - 1)) ? '0 : r_clr + HAW'(1);
            end
            if (i_cmd.out_load) begin
                r_rdpos <= r_rdpos + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key  <= i_key;
            r_last <= i_last;
        end else if (i_cmd.sc_hist_rd) begin
            r_key <= src_rdata;
        end
        if (i_cmd.lh_rd || i_cmd.pf_rd || i_cmd.sc_hist_rd) begin
            r_haddr <= h_raddr;
        end
        if (i_cmd.out_load) begin
            r_key_out <= res_rdata;
            r_final   <= (r_rdpos + CW'(1) == r_count);
            r_status  <= lsd_pkg::STATUS_OK;
        end else if (i_cmd.out_err) begin
            r_key_out <= '0;
            r_final   <= 1'b0;
            r_status  <= lsd_pkg::STATUS_EMPTY;
        end
    end

    assign o_sts.full     = (r_count == CW'(CAPACITY));
    assign o_sts.last     = r_last;
    assign o_sts.byte_end = byte_end;
    assign o_sts.dig_end  = (r_dig == '1);
    assign o_sts.idx_end  = (r_idx == r_count);
    assign o_sts.clr_end  = (r_clr == HAW'(HD - 1));
    assign o_sts.rd_ok    = r_sorted && (r_rdpos < r_count);

    assign o_key    = r_key_out;
    assign o_final  = r_final;
    assign o_status = r_status;

endmodule

FILE: rtl/lsd_ctrl.sv
// Controller: sequences loads, sort passes, histogram clear and reads.
`timescale 1ns / 1ps

module lsd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_op,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output lsd_pkg::t_cmd o_cmd,
    input  lsd_pkg::t_sts i_sts
);

    lsd_pkg::t_state r_state;
    lsd_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            slot_free;

    assign slot_free = ~r_out_valid | i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsd_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            lsd_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_end) begin
                    n_state = lsd_pkg::ST_IDLE;
                end
            end
            lsd_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_s_op == lsd_pkg::OP_READ) begin
                        n_state = lsd_pkg::ST_READ;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = lsd_pkg::ST_LOAD;
                    end
                end
            end
            lsd_pkg::ST_LOAD: begin
                // drop the key when the store is full; the mark still counts
                if (!i_sts.full) begin
                    o_cmd.store_key = 1'b1;
                    n_state         = lsd_pkg::ST_LH_RD;
                end else if (i_sts.last) begin
                    n_state = lsd_pkg::ST_PF_RD;
                end else begin
                    n_state = lsd_pkg::ST_IDLE;
                end
            end
            lsd_pkg::ST_LH_RD: begin
                o_cmd.lh_rd = 1'b1;
                n_state     = lsd_pkg::ST_LH_WR;
            end
            lsd_pkg::ST_LH_WR: begin
                o_cmd.lh_wr = 1'b1;
                if (!i_sts.byte_end) begin
                    n_state = lsd_pkg::ST_LH_RD;
                end else if (i_sts.last) begin
                    n_state = lsd_pkg::ST_PF_RD;
                end else begin
                    n_state = lsd_pkg::ST_IDLE;
                end
            end
            lsd_pkg::ST_PF_RD: begin
                o_cmd.pf_rd = 1'b1;
                n_state     = lsd_pkg::ST_PF_WR;
            end
            lsd_pkg::ST_PF_WR: begin
                o_cmd.pf_wr = 1'b1;
                n_state     = i_sts.dig_end ? lsd_pkg::ST_SC_KEY : lsd_pkg::ST_PF_RD;
            end
            lsd_pkg::ST_SC_KEY: begin
                if (i_sts.idx_end) begin
                    o_cmd.pass_next = 1'b1;
                    if (i_sts.byte_end) begin
                        o_cmd.finish = 1'b1;
                        n_state      = lsd_pkg::ST_CLEAR;
                    end else begin
                        n_state = lsd_pkg::ST_PF_RD;
                    end
                end else begin
                    n_state = lsd_pkg::ST_SC_HIST;
                end
            end
            lsd_pkg::ST_SC_HIST: begin
                o_cmd.sc_hist_rd = 1'b1;
                n_state          = lsd_pkg::ST_SC_WR;
            end
            lsd_pkg::ST_SC_WR: begin
                o_cmd.sc_wr = 1'b1;
                n_state     = lsd_pkg::ST_SC_KEY;
            end
            lsd_pkg::ST_READ: begin
                // hold until the output register can take the result
                if (slot_free) begin
                    if (i_sts.rd_ok) begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = lsd_pkg::ST_RDATA;
                    end else begin
                        o_cmd.out_err = 1'b1;
                        n_state       = lsd_pkg::ST_IDLE;
                    end
                end
            end
            lsd_pkg::ST_RDATA: begin
                o_cmd.out_load = 1'b1;
                n_state        = lsd_pkg::ST_IDLE;
            end
            default: begin
                n_state = lsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid & ~i_m_tready;
        if (o_cmd.out_load || o_cmd.out_err) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule
